FILE: rtl/core/sparse_matrix_accumulate_table_macros.svh
// ----------------------------------------------------------------------------
// Sparse matrix accumulate table assertion macros
// Shared concurrent assertion forms for the sparse matrix table RTL.
// ----------------------------------------------------------------------------
`ifndef SPARSE_MATRIX_ACCUMULATE_TABLE_MACROS_SVH
`define SPARSE_MATRIX_ACCUMULATE_TABLE_MACROS_SVH

// Checked at every rising edge of clk_i outside reset.
`define SMAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising edge of clk_i, reset included.
`define SMAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/core/smat_pkg.sv
// ----------------------------------------------------------------------------
// Sparse matrix accumulate table package
// Shared types, codes and constants of the sparse matrix table.
// ----------------------------------------------------------------------------
package smat_pkg;

  localparam int unsigned ENTRIES_DEF = 64;
  localparam int unsigned MAX_DIM     = 1024;
  localparam logic [16:0] DIM_MAX     = 17'(MAX_DIM);

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_ADD  = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_RANK = 2'd2;

  typedef struct packed {
    logic [10:0] row;
    logic [10:0] col;
    logic [31:0] value;
  } entry_t;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic rem;
    logic sum;
  } cell_cmd_t;

endpackage

FILE: rtl/core/smat_cell.sv
// ----------------------------------------------------------------------------
// Sparse matrix table cell
// Holds one entry, compares it with the key and shifts with its neighbours.
// ----------------------------------------------------------------------------
module smat_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  smat_pkg::cell_cmd_t cmd_i,
  input  smat_pkg::entry_t   key_i,
  input  logic               valid_i,
  input  smat_pkg::entry_t   left_i,
  input  logic               left_lt_i,
  input  smat_pkg::entry_t   right_i,
  output smat_pkg::entry_t   entry_o,
  output logic               lt_o,
  output logic               eq_o,
  output logic               zero_o
);

  smat_pkg::entry_t entry_q;
  logic             lt_q;
  logic             eq_q;
  logic [31:0]      sum;

  assign sum     = entry_q.value + key_i.value;
  assign entry_o = entry_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;
  assign zero_o  = eq_q && (sum == 32'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (cmd_i.cmp) begin
      lt_q <= valid_i && ((entry_q.row < key_i.row) ||
              ((entry_q.row == key_i.row) && (entry_q.col < key_i.col)));
      eq_q <= valid_i && (entry_q.row == key_i.row) && (entry_q.col == key_i.col);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins && !lt_q) begin
      entry_q <= left_lt_i ? key_i : left_i;
    end else if (cmd_i.rem && !lt_q) begin
      entry_q <= right_i;
    end else if (cmd_i.sum && eq_q) begin
      entry_q.value <= sum;
    end
  end

endmodule

FILE: rtl/core/sparse_matrix_accumulate_table.sv
// ----------------------------------------------------------------------------
// Sparse matrix accumulate table
// Row-major sorted table of sparse matrix entries built from a cell chain.
// ----------------------------------------------------------------------------
// An item is transferred at a rising edge where start is high and busy is
// low. func selects load, add or read by rank; row, col, value and rank
// carry the operands. Every item gives exactly one result, shown on the
// result ports for a single cycle while done_o is high, once the item has
// passed through the compare and update states.
// Each item passes through a compare state, in which every cell compares
// its entry with the key, and an update state, in which the cells sum, take
// the key or shift from a neighbour at once. busy is high only in the
// compare state, so a new item can be taken in the previous update state.
// The receiver cannot stall: a result is gone after its cycle, and the
// next item may be transferred in the cycle that shows the previous result.
// Reset empties the table and clears all control state; cell contents are
// left as they are and are never read before being written.
// ----------------------------------------------------------------------------
`include "sparse_matrix_accumulate_table_macros.svh"

module sparse_matrix_accumulate_table #(
  parameter int unsigned MAX_ENTRIES = smat_pkg::ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func_i,
  input  logic [10:0]        row_i,
  input  logic [10:0]        col_i,
  input  logic signed [31:0] value_i,
  input  logic [5:0]         rank_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [10:0]        out_row_o,
  output logic [10:0]        out_col_o,
  output logic signed [31:0] out_value_o,
  output logic [6:0]         entry_count_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic             accept;
  logic [1:0]       func_q;
  smat_pkg::entry_t key_q;
  logic [5:0]       rank_q;
  logic [CNT_W-1:0] count_q, count_d;

  smat_pkg::cell_cmd_t cmd;
  smat_pkg::entry_t    cell_ent [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] lt_vec, eq_vec, zero_vec;

  smat_pkg::entry_t rd_ent;
  logic             in_range, is_fold, rank_ok;
  logic [1:0]       status_d;
  smat_pkg::entry_t res_d;

  logic             done_q;
  logic [1:0]       status_q;
  smat_pkg::entry_t res_q;
  logic [6:0]       ecount_q;

  assign busy   = (state_q == ST_CMP);
  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_CMP;
      ST_CMP:  state_d = ST_UPD;
      ST_UPD:  state_d = accept ? ST_CMP : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= (state_q == ST_UPD);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q      <= func_i;
      key_q.row   <= row_i;
      key_q.col   <= col_i;
      key_q.value <= value_i;
      rank_q      <= rank_i;
    end
    if (state_q == ST_UPD) begin
      status_q <= status_d;
      res_q    <= res_d;
      ecount_q <= 7'(count_d);
    end
  end

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    smat_pkg::entry_t left, right;
    logic             left_lt;
    if (k == 0) begin : g_first
      assign left    = key_q;
      assign left_lt = 1'b1;
    end else begin : g_mid
      assign left    = cell_ent[k-1];
      assign left_lt = lt_vec[k-1];
    end
    if (k == MAX_ENTRIES - 1) begin : g_last
      assign right = cell_ent[k];
    end else begin : g_inner
      assign right = cell_ent[k+1];
    end

    smat_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .key_i     (key_q),
      .valid_i   (CNT_W'(k) < count_q),
      .left_i    (left),
      .left_lt_i (left_lt),
      .right_i   (right),
      .entry_o   (cell_ent[k]),
      .lt_o      (lt_vec[k]),
      .eq_o      (eq_vec[k]),
      .zero_o    (zero_vec[k])
    );
  end

  always_comb begin
    rd_ent = '0;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      if (32'(k) == {26'd0, rank_q}) begin
        rd_ent = rd_ent | cell_ent[k];
      end
    end
  end

  assign in_range = (key_q.row != 11'd0) && (key_q.col != 11'd0) &&
                    (17'(key_q.row) <= smat_pkg::DIM_MAX) &&
                    (17'(key_q.col) <= smat_pkg::DIM_MAX);
  assign is_fold  = ((func_q == smat_pkg::FUNC_LOAD) || (func_q == smat_pkg::FUNC_ADD)) &&
                    in_range;
  assign rank_ok  = ({26'd0, rank_q} < 32'(count_q)) &&
                    ({26'd0, rank_q} < 32'(MAX_ENTRIES));

  always_comb begin
    cmd      = '0;
    cmd.cmp  = (state_q == ST_CMP);
    count_d  = count_q;
    status_d = smat_pkg::STAT_OK;
    res_d    = '0;
    if (state_q == ST_UPD) begin
      if (is_fold) begin
        if (|eq_vec) begin
          if ((func_q == smat_pkg::FUNC_ADD) && (|zero_vec)) begin
            cmd.rem = 1'b1;
            count_d = count_q - CNT_W'(1);
          end else begin
            cmd.sum = 1'b1;
          end
        end else if (count_q == CNT_W'(MAX_ENTRIES)) begin
          status_d = smat_pkg::STAT_FULL;
        end else begin
          cmd.ins = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end else if (func_q == smat_pkg::FUNC_READ) begin
        if (rank_ok) begin
          res_d = rd_ent;
        end else begin
          status_d = smat_pkg::STAT_RANK;
        end
      end
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign out_row_o     = res_q.row;
  assign out_col_o     = res_q.col;
  assign out_value_o   = res_q.value;
  assign entry_count_o = ecount_q;

  `SMAT_ASSERT(a_done_after_upd, (state_q == ST_UPD) |=> done_o, "missing result strobe")
  `SMAT_ASSERT(a_done_only_upd, done_o |-> $past(state_q == ST_UPD), "spurious result strobe")
  `SMAT_ASSERT(a_count_upd, (count_q != $past(count_q)) |-> $past(state_q == ST_UPD), "count changed outside update")
  `SMAT_ASSERT_ALWAYS(a_count_max, !rst_ni || (count_q <= CNT_W'(MAX_ENTRIES)), "count beyond table size")
  `SMAT_ASSERT(a_lt_prefix, (state_q == ST_UPD) |-> ((lt_vec & (lt_vec + 1'b1)) == '0), "unsorted table")
  `SMAT_ASSERT(a_eq_single, (state_q == ST_UPD) |-> $onehot0(eq_vec), "position stored twice")

endmodule
